// File: rtl/core/dfia_pkg.sv
`default_nettype none
package dfia_pkg;

   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_SUB       = 4'd1;
   localparam logic [3:0] OP_MUL       = 4'd2;
   localparam logic [3:0] OP_DIV       = 4'd3;
   localparam logic [3:0] OP_NEG       = 4'd4;
   localparam logic [3:0] OP_EXTEND8   = 4'd5;
   localparam logic [3:0] OP_TRUNC8    = 4'd6;
   localparam logic [3:0] OP_TO_TWOS   = 4'd7;
   localparam logic [3:0] OP_FROM_TWOS = 4'd8;

   localparam int unsigned WORD_WIDTH = 16;
   localparam logic [7:0] LOW7_MASK   = 8'h7f;
   localparam logic [15:0] HIGH_MASK  = 16'hff00;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [15:0] remainder_value;
      logic        divide_by_zero;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/core/dfia_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage.
module dfia_divider (
   input  wire logic        clock,
   input  wire logic        advance,
   input  wire logic [15:0] num,
   input  wire logic [15:0] den,
   output logic [15:0]      quotient,
   output logic [15:0]      remainder
);
   localparam int unsigned N = dfia_pkg::WORD_WIDTH;

   logic [N-1:0] rem_ff [N+1];
   logic [N-1:0] quo_ff [N+1];
   logic [N-1:0] den_ff [N+1];

   always_comb begin
      rem_ff[0] = '0;
      quo_ff[0] = num;
      den_ff[0] = den;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [N:0]   trial;
      logic [N:0]   diff;
      logic [N-1:0] rem_in;
      logic [N-1:0] quo_in;
      logic [N-1:0] rem_q;
      logic [N-1:0] quo_q;
      logic [N-1:0] den_q;
      always_comb begin
         trial = {rem_ff[s], quo_ff[s][N-1]};
         diff  = trial - {1'b0, den_ff[s]};
         if (!diff[N]) begin
            rem_in = diff[N-1:0];
            quo_in = {quo_ff[s][N-2:0], 1'b1};
         end else begin
            rem_in = trial[N-1:0];
            quo_in = {quo_ff[s][N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_q <= rem_in;
            quo_q <= quo_in;
            den_q <= den_ff[s];
         end
      end
      always_comb begin
         rem_ff[s+1] = rem_q;
         quo_ff[s+1] = quo_q;
         den_ff[s+1] = den_q;
      end
   end

   assign quotient  = quo_ff[N];
   assign remainder = rem_ff[N];
endmodule
`default_nettype wire

// File: rtl/core/dual_format_integer_alu.sv
`default_nettype none
// Path from the edge that accepts a word to the edge that can take its result: decode
// register, 16 divider stages, output register with the sign fix-up in front of it,
// the same for every opcode.
// Throughput: one word per cycle unless stalled; the divider pipeline sets the depth.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous and active high; it clears valid bits and number_format.
module dual_format_integer_alu (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dfia_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dfia_pkg::rsp_type     rsp_word,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data
);
   localparam int unsigned N     = dfia_pkg::WORD_WIDTH;
   localparam int unsigned DEPTH = N + 1;

   logic format_ff;
   always_ff @(posedge clock) begin
      if (reset) format_ff <= 1'b0;
      else if (csr_write_enable) format_ff <= csr_write_data;
   end

   // The pipeline moves as one unit whenever the output is free.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: decode. Everything except divide is finished here; divide
   // magnitudes enter the divider.
   logic [3:0] op;
   logic [N-1:0] a, b, am, bm, num, den, res_in;
   logic as, bs, sm;
   logic [N-1:0] prod;
   always_comb begin
      op = req_word.opcode;
      a  = req_word.operand_a;
      b  = req_word.operand_b;
      sm = format_ff;
      as = a[N-1];
      bs = b[N-1];
      am = {1'b0, a[N-2:0]};
      bm = {1'b0, b[N-2:0]};
      res_in = '0;
      prod = sm ? am * bm : a * b;
      if (sm) begin num = am; den = bm; end
      else begin
         num = as ? -a : a;
         den = bs ? -b : b;
      end
      case (op)
         dfia_pkg::OP_ADD: begin
            if (!sm) res_in = a + b;
            else if (as && bs) res_in = (am + bm) | {1'b1, {(N-1){1'b0}}};
            else if (as != bs) begin
               if (am >= bm) res_in = (am - bm) | {as, {(N-1){1'b0}}};
               else res_in = (bm - am) | {bs, {(N-1){1'b0}}};
            end else res_in = am + bm;
         end
         dfia_pkg::OP_SUB: begin
            if (!sm) res_in = a - b;
            else if (as && bs)
               res_in = (bm >= am) ? bm - am : ((am - bm) | {1'b1, {(N-1){1'b0}}});
            else if (as != bs) res_in = {as, am[N-2:0] + bm[N-2:0]};
            else res_in = (am >= bm) ? am - bm : ((bm - am) | {1'b1, {(N-1){1'b0}}});
         end
         dfia_pkg::OP_MUL:
            res_in = (sm && (as != bs)) ? (prod | {1'b1, {(N-1){1'b0}}}) : prod;
         dfia_pkg::OP_NEG: res_in = sm ? (a ^ {1'b1, {(N-1){1'b0}}}) : -a;
         dfia_pkg::OP_EXTEND8: begin
            if (sm) res_in = {a[7], {(N-8){1'b0}}, a[6:0] & dfia_pkg::LOW7_MASK[6:0]};
            else res_in = a[7] ? ({8'h00, a[7:0]} | dfia_pkg::HIGH_MASK)
                               : {8'h00, a[7:0]};
         end
         dfia_pkg::OP_TRUNC8: res_in = {{(N-8){1'b0}}, as, a[6:0]};
         dfia_pkg::OP_TO_TWOS: res_in = (sm && as) ? -am : a;
         dfia_pkg::OP_FROM_TWOS:
            res_in = (sm && as) ? ((-a) | {1'b1, {(N-1){1'b0}}}) : a;
         default: res_in = '0;
      endcase
   end

   // Side band that rides along with the divider stages.
   typedef struct packed {
      logic         valid;
      logic         is_div;
      logic         dz;
      logic         sm;
      logic         as;
      logic         diff;
      logic [N-1:0] res;
   } side_type;

   side_type side_in;
   side_type side_ff [DEPTH];
   always_comb begin
      side_in.valid  = req_valid;
      side_in.is_div = op == dfia_pkg::OP_DIV;
      side_in.dz     = (op == dfia_pkg::OP_DIV) && (den == '0);
      side_in.sm     = sm;
      side_in.as     = as;
      side_in.diff   = as != bs;
      side_in.res    = res_in;
   end

   logic [N-1:0] num_ff, den_ff;
   always_ff @(posedge clock) begin
      if (reset) side_ff[0].valid <= 1'b0;
      else if (advance) side_ff[0].valid <= side_in.valid;
      if (advance) begin
         side_ff[0][$bits(side_type)-2:0] <= side_in[$bits(side_type)-2:0];
         num_ff <= num;
         den_ff <= den;
      end
   end

   for (genvar s = 1; s < DEPTH; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) side_ff[s].valid <= 1'b0;
         else if (advance) side_ff[s].valid <= side_ff[s-1].valid;
         if (advance) side_ff[s][$bits(side_type)-2:0] <= side_ff[s-1][$bits(side_type)-2:0];
      end
   end

   logic [N-1:0] quo, rem;
   dfia_divider u_div (
      .clock     (clock),
      .advance   (advance),
      .num       (num_ff),
      .den       (den_ff),
      .quotient  (quo),
      .remainder (rem)
   );

   // Final stage: apply signs to the divider output and register the word.
   side_type     last;
   dfia_pkg::rsp_type rsp_in;
   logic [N-1:0] q_fix, r_fix;
   always_comb begin
      last = side_ff[DEPTH-1];
      if (last.sm) begin
         q_fix = quo ^ {last.diff, {(N-1){1'b0}}};
         r_fix = rem ^ {last.as, {(N-1){1'b0}}};
      end else begin
         q_fix = last.diff ? -quo : quo;
         r_fix = last.as ? -rem : rem;
      end
      rsp_in.divide_by_zero = last.dz;
      if (!last.is_div) begin
         rsp_in.result_value = last.res;
         rsp_in.remainder_value = '0;
      end else if (last.dz) begin
         rsp_in.result_value = '0;
         rsp_in.remainder_value = '0;
      end else begin
         rsp_in.result_value = q_fix;
         rsp_in.remainder_value = r_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (advance) rsp_valid <= last.valid;
      if (advance) rsp_word <= rsp_in;
   end

   // A stalled result must stay put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result changed under stall");
   // The input is stalled exactly when the output holds under stall.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("stall not tied to output");
   // Divide-by-zero only ever reported with zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.divide_by_zero |->
         rsp_word.result_value == '0 && rsp_word.remainder_value == '0)
      else $error("divide by zero with data");
endmodule
`default_nettype wire
